// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// signal held while a word waits on a stalled channel
`define MT_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("stalled signal changed");

`endif

// ----- src/mt64_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mt64_pkg;

  localparam int STATE_WORDS  = 312;
  localparam int TWIST_OFFSET = 156;
  localparam int SW_AW        = 9;

  localparam logic [SW_AW-1:0] LAST_WORD    = 9'd311;
  localparam logic [SW_AW-1:0] WORDS_END    = 9'd312;
  localparam logic [SW_AW-1:0] NEVER_SEEDED = 9'd313;
  localparam logic [SW_AW-1:0] OFFSET_IDX   = 9'd156;

  localparam logic [63:0] MUL_LIN      = 64'd6364136223846793005;
  localparam logic [63:0] MUL_AR1      = 64'd3935559000370003845;
  localparam logic [63:0] MUL_AR2      = 64'd2862933555777941757;
  localparam logic [63:0] SEED_ARRAY   = 64'd19650218;
  localparam logic [63:0] SEED_DEFAULT = 64'd5489;
  localparam logic [63:0] TWIST_RESET  = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UPPER_MASK   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LOWER_MASK   = 64'h000000007FFFFFFF;
  localparam logic [63:0] TOP_BIT      = 64'h8000000000000000;
  localparam logic [63:0] TEMPER_A     = 64'h5555555555555555;
  localparam logic [63:0] TEMPER_B     = 64'h71D67FFFEDA60000;
  localparam logic [63:0] TEMPER_C     = 64'hFFF7EEE000000000;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_KEY  = 2'd1,
    OP_GEN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KEY, ST_LIN_W0, ST_LIN_GO, ST_LIN_WAIT,
    ST_AR1_INIT, ST_AR1_GO, ST_AR1_WAIT, ST_AR1_WRAP,
    ST_AR2_INIT, ST_AR2_GO, ST_AR2_WAIT, ST_AR2_WRAP, ST_AR_END,
    ST_TW_LD0, ST_TW_LD1, ST_TW_A, ST_TW_B, ST_TW_C,
    ST_GEN_RD, ST_GEN_T, ST_FINISH
  } state_t;

  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] x;
    x = w;
    x = x ^ ((x >> 29) & TEMPER_A);
    x = x ^ ((x << 17) & TEMPER_B);
    x = x ^ ((x << 37) & TEMPER_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- src/mt64_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mt64_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] value;
  logic        last_key;
  modport source(output valid, operation, value, last_key, input ready);
  modport sink(input valid, operation, value, last_key, output ready);
endinterface

interface mt64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  logic        key_dropped;
  modport source(output valid, random_word, key_dropped, input ready);
  modport sink(input valid, random_word, key_dropped, output ready);
endinterface

interface mt64_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/mt64_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mt64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/mt64_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// low 64 bits of a 64x64 product, one 32x32 partial product a cycle
module mt64_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] opa, opb;
  logic [63:0] pp, addend;

  always_comb begin
    opa    = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    opb    = (step_r == 2'd1) ? b_r[63:32] : b_r[31:0];
    pp     = opa * opb;
    addend = (step_r == 2'd0) ? pp : {pp[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= 64'd0;
    end else if (busy_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- src/mersenne_twister_64_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// 64-bit mersenne twister with a 312-word state memory and a key store of KEY_DEPTH words.
// every input word gives exactly one result word: a tempered output for generate, zero
// otherwise, with key_dropped set when a key word found the key store full. a generate
// from a live state reads the next state word and tempers it; when the state is used up
// the twist first runs over every entry, its pace set by the single read port of the
// state memory. seeding from a value runs each entry through the shared 32x32 multiplier;
// a last key word adds the two mixing passes over max(keys,312) plus 311 entries. one
// word is worked on at a time; a new word is taken while the previous result still
// waits in the output register.
module mersenne_twister_64_generator #(
  parameter int KEY_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mt64_in_if.sink   in_ch,
  mt64_out_if.source out_ch,
  mt64_cfg_if.sink  cfg_ch
);
  localparam int KCW  = $clog2(KEY_DEPTH + 1);
  localparam int KAW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KMAX = (KEY_DEPTH > mt64_pkg::STATE_WORDS) ? KEY_DEPTH
                                                            : mt64_pkg::STATE_WORDS;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int AW   = mt64_pkg::SW_AW;

  mt64_pkg::state_t state_r, state_nxt;

  // control and working registers
  mt64_pkg::op_t    op_r;
  logic             last_r;
  logic [63:0]      value_r;
  logic [63:0]      twist_r;
  logic [AW-1:0]    idx_r;      // word index, 313 until first seeding
  logic [KCW-1:0]   kcount_r;
  logic [AW-1:0]    n_r, i_r;
  logic [KCW-1:0]   j_r;
  logic [KW-1:0]    k_r;
  logic [63:0]      prev_r;     // always the state word just below the one being mixed
  logic [63:0]      cur_r, next_r;
  logic [63:0]      res_word_r;
  logic             res_drop_r;
  logic [63:0]      out_word_r;
  logic             out_drop_r, out_valid_r;

  // state memory
  logic             sw_we;
  logic [AW-1:0]    sw_waddr, sw_raddr;
  logic [63:0]      sw_wdata, sw_rdata;

  // key store
  logic             ks_we;
  logic [63:0]      ks_rdata;

  // multiplier
  logic             mul_start, mul_done;
  logic [63:0]      mul_a, mul_b, mul_prod;

  // derived values
  logic [63:0]      lin_word, ar1_word, ar2_word, key_word, mix_x, twist_word;
  logic [AW-1:0]    tw_next_addr, tw_off_addr;
  logic [KCW-1:0]   j_inc;
  logic             in_acc, out_free, key_room;

  mt64_ram #(.WIDTH(64), .DEPTH(mt64_pkg::STATE_WORDS)) u_state_ram (
    .clk  (clk),
    .we   (sw_we),
    .waddr(sw_waddr),
    .wdata(sw_wdata),
    .raddr(sw_raddr),
    .rdata(sw_rdata)
  );

  mt64_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk  (clk),
    .we   (ks_we),
    .waddr(kcount_r[KAW-1:0]),
    .wdata(value_r),
    .raddr(j_r[KAW-1:0]),
    .rdata(ks_rdata)
  );

  mt64_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign key_room = kcount_r < KCW'(KEY_DEPTH);

  assign in_ch.ready      = (state_r == mt64_pkg::ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.random_word = out_word_r;
  assign out_ch.key_dropped = out_drop_r;
  assign cfg_ch.ready     = 1'b1;

  // datapath values
  always_comb begin
    mul_a      = prev_r ^ (prev_r >> 62);
    j_inc      = j_r + KCW'(1);
    key_word   = (kcount_r == '0) ? 64'd0 : ks_rdata;
    lin_word   = mul_prod + {{(64-AW){1'b0}}, n_r};
    ar1_word   = (sw_rdata ^ mul_prod) + key_word + {{(64-KCW){1'b0}}, j_r};
    ar2_word   = (sw_rdata ^ mul_prod) - {{(64-AW){1'b0}}, i_r};
    mix_x      = (cur_r & mt64_pkg::UPPER_MASK) | (next_r & mt64_pkg::LOWER_MASK);
    twist_word = sw_rdata ^ (mix_x >> 1) ^ (mix_x[0] ? twist_r : 64'd0);
    tw_next_addr = (n_r == mt64_pkg::LAST_WORD) ? '0 : n_r + AW'(1);
    tw_off_addr  = (n_r < mt64_pkg::OFFSET_IDX) ? n_r + mt64_pkg::OFFSET_IDX
                                                 : n_r - mt64_pkg::OFFSET_IDX;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mt64_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mt64_pkg::op_t'(in_ch.operation))
            mt64_pkg::OP_SEED: state_nxt = mt64_pkg::ST_LIN_W0;
            mt64_pkg::OP_KEY:  state_nxt = mt64_pkg::ST_KEY;
            mt64_pkg::OP_GEN: begin
              if (idx_r == mt64_pkg::NEVER_SEEDED) begin
                state_nxt = mt64_pkg::ST_LIN_W0;
              end else if (idx_r == mt64_pkg::WORDS_END) begin
                state_nxt = mt64_pkg::ST_TW_LD0;
              end else begin
                state_nxt = mt64_pkg::ST_GEN_RD;
              end
            end
            default: state_nxt = mt64_pkg::ST_FINISH;
          endcase
        end
      end
      mt64_pkg::ST_KEY:    state_nxt = last_r ? mt64_pkg::ST_LIN_W0 : mt64_pkg::ST_FINISH;
      mt64_pkg::ST_LIN_W0: state_nxt = mt64_pkg::ST_LIN_GO;
      mt64_pkg::ST_LIN_GO: state_nxt = mt64_pkg::ST_LIN_WAIT;
      mt64_pkg::ST_LIN_WAIT: begin
        if (mul_done) begin
          if (n_r != mt64_pkg::LAST_WORD) begin
            state_nxt = mt64_pkg::ST_LIN_GO;
          end else begin
            unique case (op_r)
              mt64_pkg::OP_KEY: state_nxt = mt64_pkg::ST_AR1_INIT;
              mt64_pkg::OP_GEN: state_nxt = mt64_pkg::ST_TW_LD0;
              default:          state_nxt = mt64_pkg::ST_FINISH;
            endcase
          end
        end
      end
      mt64_pkg::ST_AR1_INIT: state_nxt = mt64_pkg::ST_AR1_GO;
      mt64_pkg::ST_AR1_GO:   state_nxt = mt64_pkg::ST_AR1_WAIT;
      mt64_pkg::ST_AR1_WAIT: begin
        if (mul_done) begin
          if (i_r == mt64_pkg::LAST_WORD) begin
            state_nxt = mt64_pkg::ST_AR1_WRAP;
          end else if (k_r == KW'(1)) begin
            state_nxt = mt64_pkg::ST_AR2_INIT;
          end else begin
            state_nxt = mt64_pkg::ST_AR1_GO;
          end
        end
      end
      mt64_pkg::ST_AR1_WRAP:
        state_nxt = (k_r == '0) ? mt64_pkg::ST_AR2_INIT : mt64_pkg::ST_AR1_GO;
      mt64_pkg::ST_AR2_INIT: state_nxt = mt64_pkg::ST_AR2_GO;
      mt64_pkg::ST_AR2_GO:   state_nxt = mt64_pkg::ST_AR2_WAIT;
      mt64_pkg::ST_AR2_WAIT: begin
        if (mul_done) begin
          if (i_r == mt64_pkg::LAST_WORD) begin
            state_nxt = mt64_pkg::ST_AR2_WRAP;
          end else if (k_r == KW'(1)) begin
            state_nxt = mt64_pkg::ST_AR_END;
          end else begin
            state_nxt = mt64_pkg::ST_AR2_GO;
          end
        end
      end
      mt64_pkg::ST_AR2_WRAP:
        state_nxt = (k_r == '0) ? mt64_pkg::ST_AR_END : mt64_pkg::ST_AR2_GO;
      mt64_pkg::ST_AR_END: state_nxt = mt64_pkg::ST_FINISH;
      mt64_pkg::ST_TW_LD0: state_nxt = mt64_pkg::ST_TW_LD1;
      mt64_pkg::ST_TW_LD1: state_nxt = mt64_pkg::ST_TW_A;
      mt64_pkg::ST_TW_A:   state_nxt = mt64_pkg::ST_TW_B;
      mt64_pkg::ST_TW_B:   state_nxt = mt64_pkg::ST_TW_C;
      mt64_pkg::ST_TW_C:
        state_nxt = (n_r == mt64_pkg::LAST_WORD) ? mt64_pkg::ST_GEN_RD : mt64_pkg::ST_TW_A;
      mt64_pkg::ST_GEN_RD: state_nxt = mt64_pkg::ST_GEN_T;
      mt64_pkg::ST_GEN_T:  state_nxt = mt64_pkg::ST_FINISH;
      mt64_pkg::ST_FINISH: state_nxt = out_free ? mt64_pkg::ST_IDLE : mt64_pkg::ST_FINISH;
      default:             state_nxt = mt64_pkg::ST_IDLE;
    endcase
  end

  // memory, key store and multiplier controls
  always_comb begin
    sw_we     = 1'b0;
    sw_waddr  = i_r;
    sw_wdata  = prev_r;
    sw_raddr  = i_r;
    ks_we     = 1'b0;
    mul_start = 1'b0;
    mul_b     = mt64_pkg::MUL_LIN;
    unique case (state_r)
      mt64_pkg::ST_KEY: ks_we = key_room;
      mt64_pkg::ST_LIN_W0: begin
        sw_we    = 1'b1;
        sw_waddr = '0;
        sw_wdata = prev_r;
      end
      mt64_pkg::ST_LIN_GO: mul_start = 1'b1;
      mt64_pkg::ST_LIN_WAIT: begin
        sw_we    = mul_done;
        sw_waddr = n_r;
        sw_wdata = lin_word;
      end
      mt64_pkg::ST_AR1_GO: begin
        mul_start = 1'b1;
        mul_b     = mt64_pkg::MUL_AR1;
      end
      mt64_pkg::ST_AR1_WAIT: begin
        sw_we    = mul_done;
        sw_wdata = ar1_word;
      end
      mt64_pkg::ST_AR2_GO: begin
        mul_start = 1'b1;
        mul_b     = mt64_pkg::MUL_AR2;
      end
      mt64_pkg::ST_AR2_WAIT: begin
        sw_we    = mul_done;
        sw_wdata = ar2_word;
      end
      mt64_pkg::ST_AR1_WRAP, mt64_pkg::ST_AR2_WRAP: begin
        sw_we    = 1'b1;
        sw_waddr = '0;
        sw_wdata = prev_r;
      end
      mt64_pkg::ST_AR_END: begin
        sw_we    = 1'b1;
        sw_waddr = '0;
        sw_wdata = mt64_pkg::TOP_BIT;
      end
      mt64_pkg::ST_TW_LD0: sw_raddr = '0;
      mt64_pkg::ST_TW_A:   sw_raddr = tw_next_addr;
      mt64_pkg::ST_TW_B:   sw_raddr = tw_off_addr;
      mt64_pkg::ST_TW_C: begin
        sw_we    = 1'b1;
        sw_waddr = n_r;
        sw_wdata = twist_word;
      end
      mt64_pkg::ST_GEN_RD: sw_raddr = idx_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mt64_pkg::ST_IDLE;
      twist_r     <= mt64_pkg::TWIST_RESET;
      idx_r       <= mt64_pkg::NEVER_SEEDED;
      kcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        twist_r <= cfg_ch.data;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        mt64_pkg::ST_KEY: begin
          if (key_room) begin
            kcount_r <= kcount_r + KCW'(1);
          end
        end
        mt64_pkg::ST_LIN_WAIT: begin
          if (mul_done && n_r == mt64_pkg::LAST_WORD) begin
            idx_r <= mt64_pkg::WORDS_END;
          end
        end
        mt64_pkg::ST_AR_END: begin
          kcount_r <= '0;
          idx_r    <= mt64_pkg::WORDS_END;
        end
        mt64_pkg::ST_TW_C: begin
          if (n_r == mt64_pkg::LAST_WORD) begin
            idx_r <= '0;
          end
        end
        mt64_pkg::ST_GEN_T: idx_r <= idx_r + AW'(1);
        mt64_pkg::ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and loop registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      mt64_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_r       <= mt64_pkg::op_t'(in_ch.operation);
          value_r    <= in_ch.value;
          last_r     <= in_ch.last_key;
          res_word_r <= 64'd0;
          res_drop_r <= 1'b0;
          prev_r     <= (mt64_pkg::op_t'(in_ch.operation) == mt64_pkg::OP_SEED) ?
                        in_ch.value : mt64_pkg::SEED_DEFAULT;
        end
      end
      mt64_pkg::ST_KEY: begin
        res_drop_r <= !key_room;
        prev_r     <= mt64_pkg::SEED_ARRAY;
      end
      mt64_pkg::ST_LIN_W0: n_r <= AW'(1);
      mt64_pkg::ST_LIN_WAIT: begin
        if (mul_done) begin
          prev_r <= lin_word;
          n_r    <= n_r + AW'(1);
        end
      end
      mt64_pkg::ST_AR1_INIT: begin
        i_r    <= AW'(1);
        j_r    <= '0;
        k_r    <= (KW'(kcount_r) > KW'(mt64_pkg::STATE_WORDS)) ? KW'(kcount_r)
                                                                : KW'(mt64_pkg::STATE_WORDS);
        prev_r <= mt64_pkg::SEED_ARRAY;
      end
      mt64_pkg::ST_AR1_WAIT: begin
        if (mul_done) begin
          prev_r <= ar1_word;
          i_r    <= i_r + AW'(1);
          j_r    <= (j_inc >= kcount_r) ? '0 : j_inc;
          k_r    <= k_r - KW'(1);
        end
      end
      mt64_pkg::ST_AR1_WRAP, mt64_pkg::ST_AR2_WRAP: i_r <= AW'(1);
      mt64_pkg::ST_AR2_INIT: k_r <= KW'(mt64_pkg::STATE_WORDS - 1);
      mt64_pkg::ST_AR2_WAIT: begin
        if (mul_done) begin
          prev_r <= ar2_word;
          i_r    <= i_r + AW'(1);
          k_r    <= k_r - KW'(1);
        end
      end
      mt64_pkg::ST_TW_LD0: n_r <= '0;
      mt64_pkg::ST_TW_LD1: cur_r <= sw_rdata;
      mt64_pkg::ST_TW_B:   next_r <= sw_rdata;
      mt64_pkg::ST_TW_C: begin
        cur_r <= next_r;
        n_r   <= n_r + AW'(1);
      end
      mt64_pkg::ST_GEN_T: res_word_r <= mt64_pkg::temper(sw_rdata);
      mt64_pkg::ST_FINISH: begin
        if (out_free) begin
          out_word_r <= res_word_r;
          out_drop_r <= res_drop_r;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/mt64_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mt64_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] random_word,
  input wire logic        key_dropped
);
  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `MT_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `MT_ASSERT_HOLD(a_word_hold, clk, rst_n, out_valid, out_ready, random_word)
  `MT_ASSERT(a_no_spurious, clk, rst_n, out_valid |-> (pend_r != 2'd0))
  `MT_ASSERT(a_one_ahead, clk, rst_n, in_acc |-> (pend_r == 2'd0 || pend_r == 2'd1))
  `MT_ASSERT(a_drop_zero, clk, rst_n, (out_valid && key_dropped) |-> (random_word == 64'd0))
endmodule

bind mersenne_twister_64_generator mt64_chk u_mt64_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .random_word(out_ch.random_word),
  .key_dropped(out_ch.key_dropped)
);
`default_nettype wire
